### rtl/point_in_triangle_test_assert.svh
// Assertion macros for the point-in-triangle pipeline.
`ifndef POINT_IN_TRIANGLE_TEST_ASSERT_SVH
`define POINT_IN_TRIANGLE_TEST_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define PTT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("point_in_triangle_test: assertion failed");

`define PTT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("point_in_triangle_test: assertion failed");

`else

`define PTT_ASSERT_NOW(lbl, ante, cons)

`define PTT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/ptt_pkg.sv
package ptt_pkg;

    // multiplier operand limb width
    localparam int LIMB = 32;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_TOL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUM_TOL   = 2'd1;

    localparam logic [1:0] STATUS_TESTED     = 2'd0;
    localparam logic [1:0] STATUS_OFF_PLANE  = 2'd1;
    localparam logic [1:0] STATUS_DEGENERATE = 2'd2;

    localparam logic [CFG_W-1:0] PLANE_TOL_RESET = 16'd7;
    localparam logic [CFG_W-1:0] SUM_TOL_RESET   = 16'd66;

    // latency of ptt_mul: magnitude stage, partial products, adder tree, sign stage
    function automatic int mul_lat(input int aw, input int bw);
        int na;
        int nb;
        na = (aw + LIMB - 1) / LIMB;
        nb = (bw + LIMB - 1) / LIMB;
        return 3 + $clog2(na * nb);
    endfunction

endpackage

### rtl/point_in_triangle_test.sv
// Channel   Dir  Handshake           Payload
// s_        in   s_tvalid/s_tready   point xyz, vertex a xyz, b xyz, c xyz
// m_        out  m_tvalid/m_tready   inside_res, status
// cfg_      in   cfg_we              plane_tolerance (0), sum_tolerance (1)
//
// One word per cycle enters while s_tready is high; the path runs through the two
// multiplier levels, the one-bit-per-stage divider (2*FRAC_BITS+1 stages) and the
// square root stages.
// Synchronous active-low reset clears valid bits and loads the tolerance resets.
// A stall freezes every stage; a two-entry output stage keeps taking words while
// one result waits, and s_tready drops only once both entries are full.
`include "point_in_triangle_test_assert.svh"

module point_in_triangle_test #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic aclk,
    input  logic aresetn,
    // point_x, point_y, point_z, vertex_a_x..z, vertex_b_x..z, vertex_c_x..z
    input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic s_tvalid,
    output logic s_tready,
    // inside_res, status[1:0], zero pad
    output logic [7:0] m_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    input  logic cfg_we,
    input  logic [ptt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ptt_pkg::CFG_W-1:0]     cfg_wdata
);

    localparam int W    = COORD_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int DW   = W + 1;
    localparam int CW   = 2 * DW + 1;
    localparam int NW   = 2 * CW + 2;
    localparam int QW   = 2 * F + 1;
    localparam int ML1  = ptt_pkg::mul_lat(DW, DW);
    localparam int ML2  = ptt_pkg::mul_lat(CW, CW);
    localparam int ML3  = ptt_pkg::mul_lat(NW, NW);
    localparam int L    = 6 + ML1 + ML2 + QW + F;
    localparam int FLN  = QW + F + 1;
    localparam int ODN  = QW + F - ML3 + 1;
    localparam int DVW  = (F + 2 > ptt_pkg::CFG_W) ? F + 2 : ptt_pkg::CFG_W;

    logic en;
    logic push;
    logic [L-1:0] vld_reg;

    logic [ptt_pkg::CFG_W-1:0]   plane_tol_reg;
    logic [ptt_pkg::CFG_W-1:0]   sum_tol_reg;
    logic [2*ptt_pkg::CFG_W-1:0] tol2_reg;

    logic signed [W-1:0]  crd_reg [0:11];
    logic signed [DW-1:0] dif_reg [0:5][0:2];
    logic signed [DW-1:0] wdl_reg [0:ML1][0:2];
    logic signed [2*DW-1:0] xp_l [0:3][0:2];
    logic signed [2*DW-1:0] xp_r [0:3][0:2];
    logic signed [CW-1:0] crs_reg [0:3][0:2];
    logic signed [2*CW-1:0] sq_p [0:3][0:2];
    logic signed [2*CW-1:0] dt_p [0:2];
    logic [NW-1:0]        nn_reg;
    logic [NW-1:0]        mm_reg [0:2];
    logic signed [NW-1:0] d_reg;
    logic signed [2*NW-1:0] dd_p;
    logic signed [2*NW-1:0] lim_p;

    logic [FLN-1:0] fl_deg_reg;
    logic [FLN-1:0] fl_mgt_reg;
    logic [ODN-1:0] od_reg;

    logic [NW-1:0] dv_nn_reg  [0:QW-1];
    logic [NW-1:0] dv_rem_reg [0:QW-1][0:2];
    logic [QW-1:0] dv_q_reg   [0:QW-1][0:2];
    logic [QW-1:0] sq_x_reg   [0:F][0:2];
    logic [QW-1:0] sq_r_reg   [0:F][0:2];

    logic [DVW-1:0] rsum;
    logic [DVW-1:0] dev;
    logic           fin_inside_reg;
    logic [1:0]     fin_status_reg;

    logic       m_valid_reg;
    logic [2:0] m_data_reg;
    logic       skid_valid_reg;
    logic [2:0] skid_data_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign push     = en && vld_reg[L-1];

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_tol_reg <= ptt_pkg::PLANE_TOL_RESET;
            sum_tol_reg   <= ptt_pkg::SUM_TOL_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ptt_pkg::CFG_PLANE_TOL: plane_tol_reg <= cfg_wdata;
                ptt_pkg::CFG_SUM_TOL:   sum_tol_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        tol2_reg <= plane_tol_reg * plane_tol_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[L-2:0], s_tvalid};
        end
    end

    // input word and edge vectors
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 12; i++) begin
                crd_reg[i] <= $signed(s_tdata[i*W +: W]);
            end
            for (int c = 0; c < 3; c++) begin
                dif_reg[0][c] <= DW'(crd_reg[6+c]) - DW'(crd_reg[3+c]);
                dif_reg[1][c] <= DW'(crd_reg[9+c]) - DW'(crd_reg[3+c]);
                dif_reg[2][c] <= DW'(crd_reg[3+c]) - DW'(crd_reg[c]);
                dif_reg[3][c] <= DW'(crd_reg[6+c]) - DW'(crd_reg[c]);
                dif_reg[4][c] <= DW'(crd_reg[9+c]) - DW'(crd_reg[c]);
                dif_reg[5][c] <= DW'(crd_reg[c]) - DW'(crd_reg[3+c]);
                wdl_reg[0][c] <= dif_reg[5][c];
                for (int i = 1; i <= ML1; i++) begin
                    wdl_reg[i][c] <= wdl_reg[i-1][c];
                end
            end
        end
    end

    // cross products: triangle normal, then the three sub-triangles
    for (genvar x = 0; x < 4; x++) begin : g_cross
        localparam int UG = (x == 0) ? 0 : (x == 1) ? 3 : (x == 2) ? 4 : 2;
        localparam int VG = (x == 0) ? 1 : (x == 1) ? 4 : (x == 2) ? 2 : 3;
        for (genvar c = 0; c < 3; c++) begin : g_comp
            localparam int J = (c + 1) % 3;
            localparam int K = (c + 2) % 3;
            ptt_mul #(.AW(DW), .BW(DW)) u_mul_l (
                .aclk(aclk), .en(en),
                .a(dif_reg[UG][J]), .b(dif_reg[VG][K]), .p(xp_l[x][c])
            );
            ptt_mul #(.AW(DW), .BW(DW)) u_mul_r (
                .aclk(aclk), .en(en),
                .a(dif_reg[UG][K]), .b(dif_reg[VG][J]), .p(xp_r[x][c])
            );
            always_ff @(posedge aclk) begin
                if (en) begin
                    crs_reg[x][c] <= CW'(xp_l[x][c]) - CW'(xp_r[x][c]);
                end
            end
            ptt_mul #(.AW(CW), .BW(CW)) u_sq (
                .aclk(aclk), .en(en),
                .a(crs_reg[x][c]), .b(crs_reg[x][c]), .p(sq_p[x][c])
            );
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_dot
        ptt_mul #(.AW(CW), .BW(CW)) u_dot (
            .aclk(aclk), .en(en),
            .a(crs_reg[0][c]), .b(CW'(wdl_reg[ML1][c])), .p(dt_p[c])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nn_reg <= NW'(sq_p[0][0]) + NW'(sq_p[0][1]) + NW'(sq_p[0][2]);
            for (int k = 0; k < 3; k++) begin
                mm_reg[k] <= NW'(sq_p[k+1][0]) + NW'(sq_p[k+1][1]) + NW'(sq_p[k+1][2]);
            end
            d_reg <= NW'(dt_p[0]) + NW'(dt_p[1]) + NW'(dt_p[2]);
        end
    end

    // plane distance: d^2 against tol^2 * |n|^2
    ptt_mul #(.AW(NW), .BW(NW)) u_dd (
        .aclk(aclk), .en(en), .a(d_reg), .b(d_reg), .p(dd_p)
    );
    ptt_mul #(.AW(NW), .BW(NW)) u_lim (
        .aclk(aclk), .en(en),
        .a($signed(NW'(tol2_reg))), .b($signed(nn_reg)), .p(lim_p)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            fl_deg_reg <= {fl_deg_reg[FLN-2:0], nn_reg == '0};
            fl_mgt_reg <= {fl_mgt_reg[FLN-2:0],
                           (mm_reg[0] > nn_reg) || (mm_reg[1] > nn_reg) || (mm_reg[2] > nn_reg)};
            od_reg     <= {od_reg[ODN-2:0], dd_p > lim_p};
        end
    end

    // restoring divide, one quotient bit per stage: q = floor(M * 2^(2F) / N)
    for (genvar s = 0; s < QW; s++) begin : g_div
        logic [NW:0]   trial [0:2];
        logic [NW-1:0] src_nn;
        logic [QW-1:0] qprev [0:2];
        logic          ge    [0:2];
        if (s == 0) begin : g_first
            assign src_nn = nn_reg;
            for (genvar k = 0; k < 3; k++) begin : g_k
                assign trial[k] = {1'b0, mm_reg[k]};
                assign qprev[k] = '0;
            end
        end else begin : g_next
            assign src_nn = dv_nn_reg[s-1];
            for (genvar k = 0; k < 3; k++) begin : g_k
                assign trial[k] = {dv_rem_reg[s-1][k], 1'b0};
                assign qprev[k] = dv_q_reg[s-1][k];
            end
        end
        for (genvar k = 0; k < 3; k++) begin : g_cmp
            assign ge[k] = trial[k] >= {1'b0, src_nn};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                dv_nn_reg[s] <= src_nn;
                for (int k = 0; k < 3; k++) begin
                    dv_rem_reg[s][k] <= ge[k] ? NW'(trial[k] - {1'b0, src_nn}) : NW'(trial[k]);
                    dv_q_reg[s][k]   <= {qprev[k][QW-2:0], ge[k]};
                end
            end
        end
    end

    // integer square root, one result bit per stage
    for (genvar t = 0; t <= F; t++) begin : g_sqrt
        logic [QW-1:0] src_x [0:2];
        logic [QW-1:0] src_r [0:2];
        logic [QW-1:0] bitv;
        logic [QW:0]   cand  [0:2];
        logic          take  [0:2];
        assign bitv = QW'(1) << (2 * F - 2 * t);
        for (genvar k = 0; k < 3; k++) begin : g_k
            if (t == 0) begin : g_first
                assign src_x[k] = dv_q_reg[QW-1][k];
                assign src_r[k] = '0;
            end else begin : g_next
                assign src_x[k] = sq_x_reg[t-1][k];
                assign src_r[k] = sq_r_reg[t-1][k];
            end
            assign cand[k] = (QW+1)'(src_r[k]) + (QW+1)'(bitv);
            assign take[k] = (QW+1)'(src_x[k]) >= cand[k];
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                for (int k = 0; k < 3; k++) begin
                    sq_x_reg[t][k] <= take[k] ? QW'((QW+1)'(src_x[k]) - cand[k]) : src_x[k];
                    sq_r_reg[t][k] <= take[k] ? (src_r[k] >> 1) + bitv : src_r[k] >> 1;
                end
            end
        end
    end

    assign rsum = DVW'(sq_r_reg[F][0][F:0]) + DVW'(sq_r_reg[F][1][F:0])
                + DVW'(sq_r_reg[F][2][F:0]);
    assign dev  = (rsum >= (DVW'(1) << F)) ? rsum - (DVW'(1) << F) : (DVW'(1) << F) - rsum;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (fl_deg_reg[FLN-1]) begin
                fin_status_reg <= ptt_pkg::STATUS_DEGENERATE;
                fin_inside_reg <= 1'b0;
            end else if (od_reg[ODN-1]) begin
                fin_status_reg <= ptt_pkg::STATUS_OFF_PLANE;
                fin_inside_reg <= 1'b0;
            end else begin
                fin_status_reg <= ptt_pkg::STATUS_TESTED;
                fin_inside_reg <= !fl_mgt_reg[FLN-1] && (dev < DVW'(sum_tol_reg));
            end
        end
    end

    // output word plus skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                m_data_reg     <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!m_valid_reg || m_tready) begin
                m_data_reg  <= {fin_status_reg, fin_inside_reg};
                m_valid_reg <= 1'b1;
            end else begin
                skid_data_reg  <= {fin_status_reg, fin_inside_reg};
                skid_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_data_reg};

    `PTT_ASSERT_NOW(a_skid_needs_out, skid_valid_reg, m_valid_reg)
    `PTT_ASSERT_NEXT(a_skid_fill, push && m_valid_reg && !m_tready && !skid_valid_reg, skid_valid_reg)
    `PTT_ASSERT_NOW(a_degen_outside, vld_reg[L-1] && fin_status_reg == ptt_pkg::STATUS_DEGENERATE, !fin_inside_reg)

endmodule

### rtl/ptt_mul.sv
module ptt_mul #(
    parameter int AW = 33,
    parameter int BW = 33
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [AW-1:0] a,
    input  logic signed [BW-1:0] b,
    output logic signed [AW+BW-1:0] p
);

    localparam int L  = ptt_pkg::LIMB;
    localparam int NA = (AW + L - 1) / L;
    localparam int NB = (BW + L - 1) / L;
    localparam int NT = NA * NB;
    localparam int LV = $clog2(NT);
    localparam int NP = 1 << LV;
    localparam int RW = AW + BW;
    localparam int XW = (NA + NB) * L;

    logic [AW-1:0]     a_u;
    logic [BW-1:0]     b_u;
    logic [AW-1:0]     a_mag_reg;
    logic [BW-1:0]     b_mag_reg;
    logic [LV+1:0]     neg_reg;
    logic [NA*L-1:0]   a_ext;
    logic [NB*L-1:0]   b_ext;
    logic [2*L-1:0]    pp [0:NT-1];
    logic [RW-1:0]     tree_reg [0:LV][0:NP-1];
    logic [RW-1:0]     p_reg;

    assign a_u   = $unsigned(a);
    assign b_u   = $unsigned(b);
    assign a_ext = (NA*L)'(a_mag_reg);
    assign b_ext = (NB*L)'(b_mag_reg);

    for (genvar i = 0; i < NA; i++) begin : g_row
        for (genvar j = 0; j < NB; j++) begin : g_col
            assign pp[i*NB+j] = a_ext[i*L +: L] * b_ext[j*L +: L];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_mag_reg <= a_u[AW-1] ? (~a_u + AW'(1)) : a_u;
            b_mag_reg <= b_u[BW-1] ? (~b_u + BW'(1)) : b_u;
            neg_reg   <= {neg_reg[LV:0], a_u[AW-1] ^ b_u[BW-1]};
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    tree_reg[0][i*NB+j] <= RW'(XW'(pp[i*NB+j]) << (L * (i + j)));
                end
            end
            for (int k = NT; k < NP; k++) begin
                tree_reg[0][k] <= '0;
            end
            for (int l = 1; l <= LV; l++) begin
                for (int k = 0; k < (NP >> l); k++) begin
                    tree_reg[l][k] <= tree_reg[l-1][2*k] + tree_reg[l-1][2*k+1];
                end
            end
            p_reg <= neg_reg[LV+1] ? (~tree_reg[LV][0] + RW'(1)) : tree_reg[LV][0];
        end
    end

    assign p = $signed(p_reg);

endmodule

### dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [255:0] big_t;

    typedef struct {
        logic [31:0] crd [12];
        bit          known;
        logic        want_inside;
        logic [1:0]  want_status;
    } query_row_t;

    localparam int LIMIT_CYCLES = 600000;
    localparam logic [31:0] ONE = 32'h0001_0000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic [383:0] s_tdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   m_tdata;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic         cfg_we = 1'b0;
    logic [ptt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ptt_pkg::CFG_W-1:0]     cfg_wdata = '0;

    logic [15:0] plane_tol_q;
    logic [15:0] sum_tol_q;
    logic [2:0]  verdict_q [$];
    int          send_idle_pct;
    int          stall_pct;
    int          errors;
    int          n_checked;
    int          n_inside;
    int          n_off_plane;
    int          n_degenerate;
    int          cycles;

    point_in_triangle_test u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic void cross3(input big_t ux, uy, uz, vx, vy, vz,
                                   output big_t rx, ry, rz);
        rx = uy * vz - uz * vy;
        ry = uz * vx - ux * vz;
        rz = ux * vy - uy * vx;
    endfunction

    function automatic logic [63:0] isqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // returns {status, inside}
    function automatic logic [2:0] classify(input logic [383:0] w);
        big_t p [3];
        big_t a [3];
        big_t b [3];
        big_t c [3];
        big_t nx, ny, nz, nn, d, lim, mx, my, mz;
        big_t sq [3];
        logic [63:0] r [3];
        logic [63:0] sum, dev;
        for (int i = 0; i < 3; i++) begin
            p[i] = $signed(w[32*i +: 32]);
            a[i] = $signed(w[32*(3+i) +: 32]);
            b[i] = $signed(w[32*(6+i) +: 32]);
            c[i] = $signed(w[32*(9+i) +: 32]);
        end
        cross3(b[0]-a[0], b[1]-a[1], b[2]-a[2], c[0]-a[0], c[1]-a[1], c[2]-a[2], nx, ny, nz);
        nn = nx*nx + ny*ny + nz*nz;
        if (nn == 0) return {ptt_pkg::STATUS_DEGENERATE, 1'b0};
        d = (p[0]-a[0])*nx + (p[1]-a[1])*ny + (p[2]-a[2])*nz;
        lim = big_t'(plane_tol_q) * big_t'(plane_tol_q) * nn;
        if (d*d > lim) return {ptt_pkg::STATUS_OFF_PLANE, 1'b0};
        cross3(b[0]-p[0], b[1]-p[1], b[2]-p[2], c[0]-p[0], c[1]-p[1], c[2]-p[2], mx, my, mz);
        sq[0] = mx*mx + my*my + mz*mz;
        cross3(c[0]-p[0], c[1]-p[1], c[2]-p[2], a[0]-p[0], a[1]-p[1], a[2]-p[2], mx, my, mz);
        sq[1] = mx*mx + my*my + mz*mz;
        cross3(a[0]-p[0], a[1]-p[1], a[2]-p[2], b[0]-p[0], b[1]-p[1], b[2]-p[2], mx, my, mz);
        sq[2] = mx*mx + my*my + mz*mz;
        for (int i = 0; i < 3; i++) begin
            if (sq[i] > nn) return {ptt_pkg::STATUS_TESTED, 1'b0};
            r[i] = isqrt(64'((sq[i] <<< 32) / nn));
        end
        sum = r[0] + r[1] + r[2];
        dev = (sum >= 64'(ONE)) ? sum - 64'(ONE) : 64'(ONE) - sum;
        return {ptt_pkg::STATUS_TESTED, dev < 64'(sum_tol_q)};
    endfunction

    task automatic report_mismatch(input string what, input logic [2:0] got,
                                   input logic [2:0] want);
        $display("[%0t] mismatch %s: got status %0d inside %0b, want status %0d inside %0b",
                 $realtime, what, got[2:1], got[0], want[2:1], want[0]);
        errors++;
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        logic [2:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("unexpected word", m_tdata[2:0], 3'b000);
            end else begin
                want = verdict_q.pop_front();
                n_checked++;
                if (m_tdata[2:1] != want[2:1]) report_mismatch("status", m_tdata[2:0], want);
                else if (m_tdata[0] != want[0]) report_mismatch("inside", m_tdata[2:0], want);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout with %0d results outstanding", verdict_q.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [ptt_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == ptt_pkg::CFG_PLANE_TOL) plane_tol_q = val;
        else if (idx == ptt_pkg::CFG_SUM_TOL) sum_tol_q = val;
    endtask

    task automatic send_query(input logic [383:0] w, input bit known, input logic [2:0] want);
        logic [2:0] predicted;
        s_tdata  <= w;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = classify(w);
        if (known && predicted != want) report_mismatch("typed row vs predictor", predicted, want);
        case (predicted[2:1])
            ptt_pkg::STATUS_OFF_PLANE:  n_off_plane++;
            ptt_pkg::STATUS_DEGENERATE: n_degenerate++;
            default: if (predicted[0]) n_inside++;
        endcase
        verdict_q.push_back(known ? want : predicted);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    function automatic logic [383:0] pack_row(input logic [31:0] crd [12]);
        logic [383:0] w;
        for (int i = 0; i < 12; i++) w[32*i +: 32] = crd[i];
        return w;
    endfunction

    function automatic logic [31:0] rnd_span(input int bits);
        logic [31:0] v;
        v = $urandom;
        if (bits < 32) v = $signed(v << (32 - bits)) >>> (32 - bits);
        return v;
    endfunction

    // random, collinear or barycentric points, some nudged off plane; weights past one land outside
    function automatic logic [383:0] make_query();
        logic [31:0] crd [12];
        longint      u, v;
        int          sp;
        int          kind;
        sp = $urandom_range(8, 26);
        kind = $urandom_range(99);
        for (int i = 3; i < 12; i++) crd[i] = rnd_span(sp);
        if (kind < 10) begin
            for (int i = 0; i < 12; i++) crd[i] = $urandom;
        end else if (kind < 16) begin
            // collinear vertices
            for (int i = 0; i < 3; i++)
                crd[9+i] = crd[3+i] + 32'($signed(crd[6+i] - crd[3+i]) * $urandom_range(0, 3));
            for (int i = 0; i < 3; i++) crd[i] = rnd_span(sp);
        end else begin
            u = longint'($urandom_range(0, 85000)) - 10000;
            v = longint'($urandom_range(0, 85000)) - 10000;
            if (kind < 60) begin
                u = $urandom_range(0, 40000);
                v = $urandom_range(0, 65536 - int'(u));
            end
            for (int i = 0; i < 3; i++)
                crd[i] = 32'(longint'($signed(crd[3+i])) +
                    ((longint'($signed(crd[6+i])) - $signed(crd[3+i])) * u +
                     (longint'($signed(crd[9+i])) - $signed(crd[3+i])) * v) / 65536);
            if (kind > 92) crd[$urandom_range(0, 2)] += rnd_span($urandom_range(2, 12));
        end
        return pack_row(crd);
    endfunction

    query_row_t rows [$];

    function automatic query_row_t row(input logic [31:0] c0, c1, c2, c3, c4, c5,
                                       c6, c7, c8, c9, c10, c11,
                                       input bit known, input logic [2:0] want);
        query_row_t r;
        r.crd = '{c0, c1, c2, c3, c4, c5, c6, c7, c8, c9, c10, c11};
        r.known = known;
        r.want_inside = want[0];
        r.want_status = want[2:1];
        return r;
    endfunction

    initial begin
        int n;
        logic [15:0] plane_set [5];
        logic [15:0] sum_set [5];
        errors = 0; n_checked = 0; n_inside = 0; n_off_plane = 0; n_degenerate = 0;
        cycles = 0; send_idle_pct = 0; stall_pct = 0;
        plane_tol_q = ptt_pkg::PLANE_TOL_RESET;
        sum_tol_q = ptt_pkg::SUM_TOL_RESET;
        plane_set = '{16'd0, 16'hFFFF, 16'd7, 16'd300, 16'd1};
        sum_set   = '{16'd0, 16'hFFFF, 16'd66, 16'd2000, 16'd1};

        // all vertices the same: degenerate
        rows.push_back(row(0,0,0, 0,0,0, 0,0,0, 0,0,0, 1, {ptt_pkg::STATUS_DEGENERATE, 1'b0}));
        rows.push_back(row('1,'1,'1, 32'h8000_0000,32'h8000_0000,32'h8000_0000,
            32'h8000_0000,32'h8000_0000,32'h8000_0000, 32'h8000_0000,32'h8000_0000,
            32'h8000_0000, 1, {ptt_pkg::STATUS_DEGENERATE, 1'b0}));
        // unit right triangle in z=0: vertex, edge, centroid, outside, above plane
        rows.push_back(row(0,0,0, 0,0,0, ONE,0,0, 0,ONE,0, 1, {ptt_pkg::STATUS_TESTED, 1'b1}));
        rows.push_back(row(0,0,ONE, 0,0,0, ONE,0,0, 0,ONE,0, 1,
            {ptt_pkg::STATUS_OFF_PLANE, 1'b0}));
        rows.push_back(row(0,0,8, 0,0,0, ONE,0,0, 0,ONE,0, 1, {ptt_pkg::STATUS_OFF_PLANE, 1'b0}));
        rows.push_back(row(0,0,7, 0,0,0, ONE,0,0, 0,ONE,0, 0, 3'b0));
        rows.push_back(row(ONE,ONE,0, 0,0,0, ONE,0,0, 0,ONE,0, 1,
            {ptt_pkg::STATUS_TESTED, 1'b0}));
        rows.push_back(row(21845,21845,0, 0,0,0, ONE,0,0, 0,ONE,0, 0, 3'b0));
        rows.push_back(row(32768,0,0, 0,0,0, ONE,0,0, 0,ONE,0, 0, 3'b0));
        rows.push_back(row(32768,32768,0, 0,0,0, ONE,0,0, 0,ONE,0, 0, 3'b0));
        rows.push_back(row(-ONE,0,0, 0,0,0, ONE,0,0, 0,ONE,0, 1, {ptt_pkg::STATUS_TESTED, 1'b0}));
        // collinear
        rows.push_back(row(0,0,0, 0,0,0, ONE,ONE,ONE, 2*ONE,2*ONE,2*ONE, 1,
            {ptt_pkg::STATUS_DEGENERATE, 1'b0}));
        // full-range coordinates
        rows.push_back(row(0,0,0, 32'h8000_0000,32'h8000_0000,0, 32'h7FFF_FFFF,
            32'h8000_0000,0, 0,32'h7FFF_FFFF,0, 0, 3'b0));
        rows.push_back(row(32'h7FFF_FFFF,32'h7FFF_FFFF,32'h7FFF_FFFF, 32'h8000_0000,
            32'h8000_0000,32'h8000_0000, 32'h7FFF_FFFF,32'h8000_0000,32'h8000_0000,
            32'h8000_0000,32'h7FFF_FFFF,32'h7FFF_FFFF, 0, 3'b0));
        rows.push_back(row(32'h8000_0000,0,32'h7FFF_FFFF, 0,0,32'h7FFF_FFFF,
            32'h7FFF_FFFF,0,32'h7FFF_FFFF, 0,32'h7FFF_FFFF,32'h7FFF_FFFF, 0, 3'b0));
        // tilted triangle, point at a vertex and on an edge; then a point below a z=3 triangle
        rows.push_back(row(ONE,0,0, ONE,0,0, 0,ONE,0, 0,0,ONE, 0, 3'b0));
        rows.push_back(row(32768,32768,0, ONE,0,0, 0,ONE,0, 0,0,ONE, 0, 3'b0));
        rows.push_back(row(-5,-5,-5, -ONE,-ONE,3, ONE,-ONE,3, 0,ONE,3, 0, 3'b0));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i])
            send_query(pack_row(rows[i].crd), rows[i].known,
                       {rows[i].want_status, rows[i].want_inside});

        for (int ph = 0; ph < 5; ph++) begin
            s_tvalid <= 1'b0;
            while (verdict_q.size() != 0) @(posedge aclk);
            write_reg(ptt_pkg::CFG_PLANE_TOL, plane_set[ph]);
            write_reg(ptt_pkg::CFG_SUM_TOL, sum_set[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 57; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 57; end
                default: begin send_idle_pct = 13; stall_pct = 13; end
            endcase
            if (ph == 4) begin send_idle_pct = 0; stall_pct = 57; end
            n = 325;
            for (int k = 0; k < n; k++) send_query(make_query(), 0, 3'b0);
        end

        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        stall_pct = 0;
        repeat (100) @(posedge aclk);
        $display("checked %0d results: %0d inside, %0d off plane, %0d degenerate",
                 n_checked, n_inside, n_off_plane, n_degenerate);
        $display("five tolerance settings incl. zero and full scale, four idle/stall mixes");
        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
